FILE: rtl/running_mean_sigma_min_max_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the running statistics unit
// Clocked on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef RUNNING_MEAN_SIGMA_MIN_MAX_UNIT_MACROS_SVH
`define RUNNING_MEAN_SIGMA_MIN_MAX_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define RMSMM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define RMSMM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define RMSMM_ASSERT_NOW(lbl, ante, cons)
`define RMSMM_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: rtl/rmsmm_pkg.sv
// ----------------------------------------------------------------------------
// rmsmm_pkg
// Types and constants shared by the running statistics unit.
// ----------------------------------------------------------------------------
package rmsmm_pkg;

    localparam logic [1:0] OP_STORE    = 2'd0;
    localparam logic [1:0] OP_REPORT   = 2'd1;
    localparam logic [1:0] OP_CLEAR    = 2'd2;
    localparam logic [1:0] OP_RESERVED = 2'd3;

    localparam logic [20:0] MAX_COUNT  = 21'd1048576;

    localparam logic [6:0] MULA_LEN = 7'd21;
    localparam logic [6:0] MULB_LEN = 7'd36;
    localparam logic [6:0] DIVV_LEN = 7'd72;
    localparam logic [6:0] SQRT_LEN = 7'd36;

    typedef struct packed {
        logic [1:0]         operation;
        logic signed [15:0] sample;
    } t_in_word;

    typedef struct packed {
        logic [20:0]        sample_count;
        logic signed [35:0] total;
        logic [50:0]        total_squares;
        logic signed [15:0] smallest;
        logic signed [15:0] largest;
        logic signed [15:0] mean_value;
        logic [15:0]        std_dev;
        logic               empty_flag;
        logic               too_few_flag;
        logic               overflow_flag;
    } t_out_word;

    typedef enum logic [3:0] {
        PH_IDLE, PH_STORE, PH_CLEAR, PH_LDA, PH_MULA, PH_LDB, PH_MULB,
        PH_LDD, PH_DIVV, PH_LDS, PH_SQRT, PH_OUT
    } t_phase;

    typedef struct packed {
        t_phase phase;
        logic   busy;
        logic   valid;
    } t_ctrl_cmd;

endpackage

FILE: rtl/rmsmm_ctrl.sv
// ----------------------------------------------------------------------------
// rmsmm_ctrl
// Sequencer: store/clear issued straight from idle, multi-phase report computation.
// ----------------------------------------------------------------------------
module rmsmm_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [1:0]          i_operation,
    output rmsmm_pkg::t_ctrl_cmd o_cmd
);
    import rmsmm_pkg::*;

    t_phase     r_state, n_state;
    logic [6:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= PH_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        o_cmd.phase = r_state;
        o_cmd.busy  = (r_state != PH_IDLE);
        o_cmd.valid = (r_state == PH_OUT);
        unique case (r_state)
            PH_IDLE: begin
                if (i_start) begin
                    priority if (i_operation == OP_STORE) o_cmd.phase = PH_STORE;
                    else if (i_operation == OP_CLEAR) o_cmd.phase = PH_CLEAR;
                    else if (i_operation == OP_REPORT) n_state = PH_LDA;
                    else o_cmd.phase = PH_IDLE;
                end
            end
            PH_LDA:  n_state = PH_MULA;
            PH_MULA: begin
                n_cnt = r_cnt + 7'd1;
                if (r_cnt == MULA_LEN - 7'd1) begin
                    n_cnt   = '0;
                    n_state = PH_LDB;
                end
            end
            PH_LDB:  n_state = PH_MULB;
            PH_MULB: begin
                n_cnt = r_cnt + 7'd1;
                if (r_cnt == MULB_LEN - 7'd1) begin
                    n_cnt   = '0;
                    n_state = PH_LDD;
                end
            end
            PH_LDD:  n_state = PH_DIVV;
            PH_DIVV: begin
                n_cnt = r_cnt + 7'd1;
                if (r_cnt == DIVV_LEN - 7'd1) begin
                    n_cnt   = '0;
                    n_state = PH_LDS;
                end
            end
            PH_LDS:  n_state = PH_SQRT;
            PH_SQRT: begin
                n_cnt = r_cnt + 7'd1;
                if (r_cnt == SQRT_LEN - 7'd1) begin
                    n_cnt   = '0;
                    n_state = PH_OUT;
                end
            end
            PH_OUT:  n_state = PH_IDLE;
            default: n_state = PH_IDLE;
        endcase
    end

endmodule

FILE: rtl/rmsmm_dp.sv
// ----------------------------------------------------------------------------
// rmsmm_dp
// Accumulators plus shift-add multiplier, restoring dividers and root unit.
// ----------------------------------------------------------------------------
module rmsmm_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rmsmm_pkg::t_ctrl_cmd i_cmd,
    input  rmsmm_pkg::t_in_word  i_item,
    output rmsmm_pkg::t_out_word o_result
);
    import rmsmm_pkg::*;

    logic [20:0]        r_count;
    logic signed [35:0] r_sum;
    logic [50:0]        r_sumsq;
    logic signed [15:0] r_min, r_max;
    logic               r_drop;

    logic [71:0] r_acc, r_mpd, r_prod_a;
    logic [35:0] r_mpr;
    logic [35:0] r_mq;
    logic [21:0] r_mr;
    logic [71:0] r_vq;
    logic [42:0] r_vr;
    logic [41:0] r_den;
    logic [71:0] r_rad;
    logic [35:0] r_root;
    logic [37:0] r_srem;

    logic signed [31:0] sq;
    logic [35:0]        mag;
    logic [72:0]        diff;
    logic [21:0]        m_try;
    logic [42:0]        v_try;
    logic [37:0]        s_try, s_trial;
    logic [15:0]        mean_mag;
    logic               empty, few;

    assign sq      = i_item.sample * i_item.sample;
    assign mag     = r_sum[35] ? 36'(-r_sum) : 36'(r_sum);
    assign diff    = {1'b0, r_prod_a} - {1'b0, r_acc};
    assign m_try   = {r_mr[20:0], r_mq[35]};
    assign v_try   = {r_vr[41:0], r_vq[71]};
    assign s_try   = {r_srem[35:0], r_rad[71:70]};
    assign s_trial = {r_root, 2'b01};

    // statistics registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_sum   <= '0;
            r_sumsq <= '0;
            r_drop  <= 1'b0;
        end else if (i_cmd.phase == PH_CLEAR) begin
            r_count <= '0;
            r_sum   <= '0;
            r_sumsq <= '0;
            r_drop  <= 1'b0;
        end else if (i_cmd.phase == PH_STORE) begin
            if (r_count >= MAX_COUNT) begin
                r_drop <= 1'b1;
            end else begin
                r_count <= r_count + 21'd1;
                r_sum   <= r_sum + 36'(i_item.sample);
                r_sumsq <= r_sumsq + {19'b0, sq};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.phase == PH_STORE && r_count < MAX_COUNT) begin
            if (r_count == '0 || i_item.sample < r_min) r_min <= i_item.sample;
            if (r_count == '0 || i_item.sample > r_max) r_max <= i_item.sample;
        end
    end

    // report arithmetic
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.phase)
            PH_LDA: begin
                r_acc <= '0;
                r_mpd <= {21'b0, r_sumsq};
                r_mpr <= {15'b0, r_count};
            end
            PH_MULA, PH_MULB: begin
                if (r_mpr[0]) r_acc <= r_acc + r_mpd;
                r_mpd <= {r_mpd[70:0], 1'b0};
                r_mpr <= {1'b0, r_mpr[35:1]};
                if (i_cmd.phase == PH_MULB) begin
                    if (m_try >= {1'b0, r_count}) begin
                        r_mr <= m_try - {1'b0, r_count};
                        r_mq <= {r_mq[34:0], 1'b1};
                    end else begin
                        r_mr <= m_try;
                        r_mq <= {r_mq[34:0], 1'b0};
                    end
                end
            end
            PH_LDB: begin
                r_prod_a <= r_acc;
                r_acc    <= '0;
                r_mpd    <= {36'b0, mag};
                r_mpr    <= mag;
                r_mq     <= mag;
                r_mr     <= '0;
            end
            PH_LDD: begin
                r_vq  <= diff[72] ? '0 : diff[71:0];
                r_vr  <= '0;
                r_den <= r_count * (r_count - 21'd1);
            end
            PH_DIVV: begin
                if (v_try >= {1'b0, r_den}) begin
                    r_vr <= v_try - {1'b0, r_den};
                    r_vq <= {r_vq[70:0], 1'b1};
                end else begin
                    r_vr <= v_try;
                    r_vq <= {r_vq[70:0], 1'b0};
                end
            end
            PH_LDS: begin
                r_rad  <= r_vq;
                r_root <= '0;
                r_srem <= '0;
            end
            PH_SQRT: begin
                r_rad <= {r_rad[69:0], 2'b00};
                if (s_try >= s_trial) begin
                    r_srem <= s_try - s_trial;
                    r_root <= {r_root[34:0], 1'b1};
                end else begin
                    r_srem <= s_try;
                    r_root <= {r_root[34:0], 1'b0};
                end
            end
            default: ;
        endcase
    end

    assign empty    = (r_count == '0);
    assign few      = (r_count <= 21'd2);
    assign mean_mag = r_mq[15:0];

    always_comb begin
        o_result.sample_count  = r_count;
        o_result.total         = r_sum;
        o_result.total_squares = r_sumsq;
        o_result.smallest      = empty ? '0 : r_min;
        o_result.largest       = empty ? '0 : r_max;
        o_result.mean_value    = empty ? '0 :
                                 (r_sum[35] ? 16'(-mean_mag) : mean_mag);
        o_result.std_dev       = few ? '0 :
                                 ((r_root[35:16] != '0) ? 16'hFFFF : r_root[15:0]);
        o_result.empty_flag    = empty;
        o_result.too_few_flag  = few;
        o_result.overflow_flag = r_drop;
    end

endmodule

FILE: rtl/running_mean_sigma_min_max_unit.sv
// ----------------------------------------------------------------------------
// running_mean_sigma_min_max_unit
// Running count, sum, sum of squares, min, max, mean and sample sigma.
// ----------------------------------------------------------------------------
// Store, clear and unused codes are handled straight from idle and o_busy
// stays low, so a sample can be accepted every cycle while no report runs.
// A report holds o_busy through a 21-step shift-add for n*sumsq, a 36-step
// shift-add for sum^2 (the mean divide runs alongside), a 72-step restoring
// divide and a 36-step root. The result word is shown for exactly one cycle
// with o_valid; the receiver must take it then.
module running_mean_sigma_min_max_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  rmsmm_pkg::t_in_word  i_item,
    output logic                 o_busy,
    output logic                 o_valid,
    output rmsmm_pkg::t_out_word o_result
);
    import rmsmm_pkg::*;
`include "running_mean_sigma_min_max_unit_macros.svh"

    t_ctrl_cmd cmd;

    rmsmm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_operation (i_item.operation),
        .o_cmd       (cmd)
    );

    rmsmm_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_item   (i_item),
        .o_result (o_result)
    );

    assign o_busy  = cmd.busy;
    assign o_valid = cmd.valid;

    `RMSMM_ASSERT_NOW(a_valid_busy, o_valid, o_busy)
    `RMSMM_ASSERT_NEXT(a_report_busy, i_start && !o_busy && i_item.operation == OP_REPORT, o_busy)
    `RMSMM_ASSERT_NEXT(a_done_idle, o_valid, !o_busy && !o_valid)

endmodule
